// File: rtl/assert_macros.svh
// Assertion shorthands, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define SCMVA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Antecedent this cycle, consequent on the next.
`define SCMVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/scmva_pkg.sv
package scmva_pkg;

  localparam int IDX_W  = 10;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int SUM_W  = 40;

  localparam int DEF_VECTOR_DEPTH = 1024;
  localparam int DEF_ROW_DEPTH    = 1024;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_ACCUM = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] row_sum;
    logic                    saturated;
  } out_res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ACC
  } state_t;

endpackage

// File: rtl/scmva_mac.sv
module scmva_mac
  import scmva_pkg::*;
(
  input  logic                    clk,
  input  logic                    mul_en,
  input  logic signed [VAL_W-1:0] mul_a,
  input  logic signed [VAL_W-1:0] mul_b,
  input  logic signed [SUM_W-1:0] acc_in,
  output logic signed [SUM_W-1:0] sum_out,
  output logic                    sat_out
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W:0]    sum_wide;

  // product registered ahead of the add
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  assign sum_wide = {acc_in[SUM_W-1], acc_in}
                  + {{(SUM_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // overflow when the two top bits disagree; clip towards the sign
  always_comb begin
    sat_out = sum_wide[SUM_W] != sum_wide[SUM_W-1];
    if (!sat_out) begin
      sum_out = sum_wide[SUM_W-1:0];
    end else if (sum_wide[SUM_W]) begin
      sum_out = SUM_MIN;
    end else begin
      sum_out = SUM_MAX;
    end
  end

endmodule

// File: rtl/sparse_csr_matvec_accumulate_core.sv
// Sparse matrix-vector multiply-accumulate over a stream of CSR nonzeros.
// Request channel: in_req is taken at a rising edge with start high and busy
//   low. Actions: load a dense-vector entry, accumulate value * vector[column]
//   into the row's sum, or read the row sum and clear it. Code 3 is a no-op.
// Result channel: every request gives one result on out_res, marked by
//   out_valid for exactly one cycle. The receiver cannot stall it.
// Steps: an accepted request passes memory read, multiply, then
//   add/saturate/write-back with the result strobe. busy drops while the
//   strobe is up, so a new request is taken only after the last one has
//   written back. The row-sum read/modify/write loop sets this; busy
//   interlocks it, so no two requests ever touch the same entry at once.
// Sums are Q24.16 in 40 bits and clip at the limits, flagging saturated.
// Reset: after rst_n the row-sum memory is swept to zero, one entry a cycle,
//   busy held high until the sweep ends. The vector memory is not cleared:
//   an entry must be loaded before an accumulate reads it.
// Out-of-range rows store nothing and report zero; out-of-range columns
//   are ignored on load and read as zero on accumulate.
module sparse_csr_matvec_accumulate_core
  import scmva_pkg::*;
#(
  parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH,
  parameter int ROW_DEPTH    = DEF_ROW_DEPTH
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_req_t  in_req,
  output logic     busy,
  output logic     out_valid,
  output out_res_t out_res
);

  localparam int VIDX_W = $clog2(VECTOR_DEPTH);
  localparam int RIDX_W = $clog2(ROW_DEPTH);
  localparam logic [RIDX_W-1:0] ROW_LAST = RIDX_W'(ROW_DEPTH - 1);

  // memories
  logic [VAL_W-1:0] vec_mem [VECTOR_DEPTH];
  logic [SUM_W-1:0] row_mem [ROW_DEPTH];

  state_t            state_r, state_nxt;
  logic [RIDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  in_req_t           req_r;
  logic              row_ok_r, col_ok_r;
  logic [VAL_W-1:0]  vec_rd_r;
  logic [SUM_W-1:0]  row_rd_r;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_res_r, out_res_nxt;

  logic accept;
  logic mul_en, fin, clr_en;
  logic row_ok, col_ok;
  logic [VIDX_W-1:0] col_idx;
  logic [RIDX_W-1:0] row_idx;

  logic              row_we;
  logic [RIDX_W-1:0] row_wa;
  logic [SUM_W-1:0]  row_wd;

  logic signed [VAL_W-1:0] vec_op;
  logic signed [SUM_W-1:0] mac_sum;
  logic                    mac_sat;

  assign accept  = start && !busy;
  assign row_ok  = 32'(in_req.row) < 32'(ROW_DEPTH);
  assign col_ok  = 32'(in_req.column) < 32'(VECTOR_DEPTH);
  assign col_idx = VIDX_W'(in_req.column);
  assign row_idx = RIDX_W'(in_req.row);

  // ---------------------------------------------------------------- FSM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ROW_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    mul_en = 1'b0;
    fin    = 1'b0;
    clr_en = 1'b0;
    unique case (state_r)
      ST_CLEAR: clr_en = 1'b1;
      ST_IDLE:  busy   = 1'b0;
      ST_READ:  mul_en = 1'b1;
      ST_ACC:   fin    = 1'b1;
      default:  busy   = 1'b1;
    endcase
  end

  // ------------------------------------------------------ request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_req;
      row_ok_r <= row_ok;
      col_ok_r <= col_ok;
    end
  end

  // vector memory: load writes at the accepting edge, reads registered
  always_ff @(posedge clk) begin
    if (accept && in_req.action == ACT_LOAD && col_ok) begin
      vec_mem[col_idx] <= in_req.value;
    end
    if (accept) begin
      vec_rd_r <= vec_mem[col_idx];
    end
  end

  // row-sum memory: one write port (clear sweep or write-back), one read
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (accept) begin
      row_rd_r <= row_mem[row_idx];
    end
  end

  // ------------------------------------------------------------ datapath
  assign vec_op = col_ok_r ? $signed(vec_rd_r) : '0;

  scmva_mac u_mac (
    .clk     (clk),
    .mul_en  (mul_en),
    .mul_a   (req_r.value),
    .mul_b   (vec_op),
    .acc_in  ($signed(row_rd_r)),
    .sum_out (mac_sum),
    .sat_out (mac_sat)
  );

  always_comb begin
    out_res_nxt   = '0;
    out_valid_nxt = fin;
    row_we        = 1'b0;
    row_wa        = RIDX_W'(req_r.row);
    row_wd        = '0;
    if (clr_en) begin
      row_we = 1'b1;
      row_wa = clr_cnt_r;
    end else if (fin && row_ok_r) begin
      unique case (req_r.action)
        ACT_LOAD: begin
          out_res_nxt.row_sum = row_rd_r;
        end
        ACT_ACCUM: begin
          out_res_nxt.row_sum   = mac_sum;
          out_res_nxt.saturated = mac_sat;
          row_we                = 1'b1;
          row_wd                = mac_sum;
        end
        ACT_READ: begin
          // report the old sum, write back zero
          out_res_nxt.row_sum = row_rd_r;
          row_we              = 1'b1;
        end
        default: begin
          out_res_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // ---------------------------------------------------------- assertions
`include "assert_macros.svh"

  `SCMVA_ASSERT_NEXT(a_accept_reads, start && !busy, state_r == ST_READ, "accept did not start a read")
  `SCMVA_ASSERT_NEXT(a_acc_gives_result, state_r == ST_ACC, out_valid, "no result after write-back")
  `SCMVA_ASSERT(a_result_source, out_valid |-> $past(state_r == ST_ACC), "stray result strobe")
  `SCMVA_ASSERT(a_sat_only_accum, out_valid && out_res.saturated |-> $past(req_r.action == ACT_ACCUM), "saturation on a non-accumulate request")

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scmva_pkg::*;

  // Unused action code; the block answers it with a zero result.
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam int CYCLE_LIMIT   = 100000;
  localparam int RANDOM_COUNT  = 50;
  localparam int TAIL_COUNT    = 12;
  localparam int SAT_RUN_LEN   = 516;  // 2^39 / 2^30 = 512 steps to clip, plus margin
  localparam int DRAIN_CYCLES  = 8;
  localparam int PRINT_CAP     = 40;

  // Predicts each result from the accepted requests and checks results in order.
  class matvec_scoreboard;
    logic signed [VAL_W-1:0] vec_mem [DEF_VECTOR_DEPTH];
    bit                      vec_valid [DEF_VECTOR_DEPTH];
    logic signed [SUM_W-1:0] row_acc [DEF_ROW_DEPTH];
    out_res_t                sums_due [$];
    int                      errors;

    function new();
      foreach (row_acc[i]) row_acc[i] = '0;
      foreach (vec_valid[i]) vec_valid[i] = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return sums_due.size();
    endfunction

    task report_mismatch(input string what);
      if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    function void note_request(input in_req_t req);
      out_res_t                res;
      logic signed [VAL_W-1:0] vec;
      longint                  acc;
      res = '0;
      case (req.action)
        ACT_LOAD: begin
          vec_mem[req.column]   = req.value;
          vec_valid[req.column] = 1'b1;
          res.row_sum = row_acc[req.row];
        end
        ACT_ACCUM: begin
          vec = vec_valid[req.column] ? vec_mem[req.column] : '0;
          acc = longint'(row_acc[req.row]) + longint'($signed(req.value)) * longint'(vec);
          if (acc > longint'(SUM_MAX)) begin
            acc = longint'(SUM_MAX);
            res.saturated = 1'b1;
          end else if (acc < longint'(SUM_MIN)) begin
            acc = longint'(SUM_MIN);
            res.saturated = 1'b1;
          end
          row_acc[req.row] = acc[SUM_W-1:0];
          res.row_sum = acc[SUM_W-1:0];
        end
        ACT_READ: begin
          res.row_sum = row_acc[req.row];
          row_acc[req.row] = '0;
        end
        default: ;
      endcase
      sums_due.push_back(res);
    endfunction

    task check_result(input out_res_t got);
      out_res_t want;
      if (sums_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result row_sum=%0d sat=%0b",
                                  got.row_sum, got.saturated));
      end else begin
        want = sums_due.pop_front();
        if (got.row_sum !== want.row_sum)
          report_mismatch($sformatf("row_sum got %0d want %0d", got.row_sum, want.row_sum));
        if (got.saturated !== want.saturated)
          report_mismatch($sformatf("saturated got %0b want %0b",
                                    got.saturated, want.saturated));
      end
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  in_req_t  in_req;
  logic     busy;
  logic     out_valid;
  out_res_t out_res;

  matvec_scoreboard sb = new();

  // Vector entries the stimulus has loaded; accumulates only ever gather from these,
  // since the vector memory is not cleared at reset.
  bit written_col [DEF_VECTOR_DEPTH];
  int written_list [$];
  int hot_rows [8];
  bit idle_free;
  int sent_count;
  int cycle_count;

  sparse_csr_matvec_accumulate_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_req   (in_req),
    .busy     (busy),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: covers the row-sum sweep after reset plus every request at worst gap.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sparse_csr_matvec_accumulate_core");
      $finish;
    end
  end

  // Results cannot be held off, so every strobe is taken at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_res);
  end

  function automatic in_req_t mk_req(input logic [1:0] act, input int row, input int col,
                                     input int val);
    in_req_t req;
    req.action = act;
    req.row    = row[IDX_W-1:0];
    req.column = col[IDX_W-1:0];
    req.value  = val[VAL_W-1:0];
    return req;
  endfunction

  // Mostly uniform, with the Q8.8 extremes showing up often.
  function automatic int pick_value();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(0, 1) ? 0 : -1;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Drives one request: optional idle gap with start low, then hold start until busy
  // is seen low at an edge. start is never dropped and raised in one step.
  task automatic send_request(input in_req_t req);
    int gap;
    if (sent_count % 64 == 0) idle_free = ($urandom_range(0, 3) == 0);
    gap = idle_free ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
    if (req.action == ACT_LOAD && !written_col[req.column]) begin
      written_col[req.column] = 1'b1;
      written_list.push_back(int'(req.column));
    end
    sent_count++;
  endtask

  // Long run of identical products into one row until it clips, then read it back.
  task automatic saturation_run(input int vec_val, input int mat_val);
    int row;
    int col;
    row = $urandom_range(0, DEF_ROW_DEPTH - 1);
    col = $urandom_range(0, DEF_VECTOR_DEPTH - 1);
    send_request(mk_req(ACT_LOAD, row, col, vec_val));
    repeat (SAT_RUN_LEN) send_request(mk_req(ACT_ACCUM, row, col, mat_val));
    send_request(mk_req(ACT_READ, row, col, 0));
  endtask

  task automatic random_request();
    int row;
    int col;
    int pick;
    pick = $urandom_range(0, 99);
    // Hot rows keep sums building up across many nonzeros.
    row = ($urandom_range(0, 3) != 0) ? hot_rows[$urandom_range(0, 7)]
                                      : $urandom_range(0, DEF_ROW_DEPTH - 1);
    if (pick < 25) begin
      col = $urandom_range(0, DEF_VECTOR_DEPTH - 1);
      send_request(mk_req(ACT_LOAD, row, col, pick_value()));
    end else if (pick < 75) begin
      col = written_list[$urandom_range(0, written_list.size() - 1)];
      send_request(mk_req(ACT_ACCUM, row, col, pick_value()));
    end else if (pick < 95) begin
      send_request(mk_req(ACT_READ, row, $urandom_range(0, DEF_VECTOR_DEPTH - 1),
                          pick_value()));
    end else begin
      send_request(mk_req(ACT_NONE, $urandom_range(0, DEF_ROW_DEPTH - 1),
                          $urandom_range(0, DEF_VECTOR_DEPTH - 1), pick_value()));
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_req      <= '0;
    cycle_count <= 0;
    sent_count  = 0;
    idle_free   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fresh sums read zero, the no-op code, index and value extremes.
    send_request(mk_req(ACT_READ,  0,    0,    0));
    send_request(mk_req(ACT_NONE,  1023, 1023, -1));
    send_request(mk_req(ACT_LOAD,  1023, 0,    32767));
    send_request(mk_req(ACT_LOAD,  0,    1023, -32768));
    send_request(mk_req(ACT_LOAD,  512,  512,  1));
    send_request(mk_req(ACT_LOAD,  5,    5,    -1));
    send_request(mk_req(ACT_ACCUM, 1023, 0,    32767));
    send_request(mk_req(ACT_ACCUM, 1023, 1023, -32768));
    send_request(mk_req(ACT_ACCUM, 0,    1023, -32768));
    send_request(mk_req(ACT_ACCUM, 0,    5,    0));
    send_request(mk_req(ACT_ACCUM, 0,    512,  -1));
    send_request(mk_req(ACT_ACCUM, 0,    5,    32767));
    // a load reports the addressed row's sum without touching it
    send_request(mk_req(ACT_LOAD,  0,    5,    -32768));
    send_request(mk_req(ACT_ACCUM, 0,    5,    -32768));
    send_request(mk_req(ACT_READ,  1023, 0,    0));
    // second read after clear must give zero
    send_request(mk_req(ACT_READ,  1023, 0,    0));
    send_request(mk_req(ACT_READ,  0,    1023, 32767));
    send_request(mk_req(ACT_NONE,  0,    0,    0));
    send_request(mk_req(ACT_ACCUM, 341,  0,    -21846));
    send_request(mk_req(ACT_READ,  341,  682,  21845));

    foreach (hot_rows[i]) hot_rows[i] = $urandom_range(0, DEF_ROW_DEPTH - 1);
    repeat (RANDOM_COUNT) random_request();

    // One clipping run per seed, at the top limit or at the bottom one.
    if ($urandom_range(0, 1) != 0) saturation_run(-32768, -32768);
    else saturation_run(-32768, 32767);
    repeat (TAIL_COUNT) random_request();

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS sparse_csr_matvec_accumulate_core");
    end else begin
      $display("FAIL sparse_csr_matvec_accumulate_core");
    end
    $finish;
  end

endmodule
